// ===== design/sks_pkg.sv =====
// ============================================================================
// sks_pkg
// Shared types and constants for the small key list sorter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sks_pkg;

    // Key: unsigned fixed point, 16 fraction bits (65536 = 1.0)
    localparam int KEY_W = 17;

    // Default capacity of the key store
    localparam int DEFAULT_MAX_KEYS = 32;

    typedef logic [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

// ===== design/sks_in_if.sv =====
// ============================================================================
// sks_in_if
// Input channel: one key per request, last key of the list marked.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface sks_in_if
    import sks_pkg::*;
();
    logic valid;
    logic ready;
    key_t key;
    logic is_last;

    modport source (output valid, output key, output is_last, input ready);
    modport sink   (input valid, input key, input is_last, output ready);
endinterface

`default_nettype wire

// ===== design/sks_out_if.sv =====
// ============================================================================
// sks_out_if
// Output channel: one sorted key per request, final key flagged.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface sks_out_if
    import sks_pkg::*;
();
    logic valid;
    logic ready;
    key_t sorted_key;
    logic end_of_list;

    modport source (output valid, output sorted_key, output end_of_list, input ready);
    modport sink   (input valid, input sorted_key, input end_of_list, output ready);
endinterface

`default_nettype wire

// ===== design/sks_key_mem.sv =====
// ============================================================================
// sks_key_mem
// Key store: one write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sks_key_mem
    import sks_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_KEYS
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire key_t                     wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output key_t                          rdata
);

    key_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/sks_minmax.sv =====
// ============================================================================
// sks_minmax
// Shared compare-exchange unit: orders two keys, flags an exchange.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sks_minmax
    import sks_pkg::*;
(
    input  wire key_t a,
    input  wire key_t b,
    output key_t      lo,
    output key_t      hi,
    output logic      swap
);

    // a is the earlier entry; exchange only when strictly greater
    assign swap = (a > b);
    assign lo   = swap ? b : a;
    assign hi   = swap ? a : b;

endmodule

`default_nettype wire

// ===== design/sort_small_key_list.sv =====
// ============================================================================
// sort_small_key_list
// Collects a list of keys and emits them in ascending order on the last one.
// ============================================================================
// Usage:
//   list   : one key per request, is_last marks the final key of the list.
//            Keys beyond MAX_KEYS are dropped (a dropped last key still
//            triggers the sort of what was kept).
//   sorted : the kept keys in ascending order, end_of_list on the largest.
// Timing:
//   A key that is not last keeps the sorter idle; keys stream back to back.
//   On the last key, n kept keys are bubble sorted in place through one
//   compare-exchange unit and a single-port-read memory: each pass walks the
//   list once and passes repeat until one makes no exchange (at most n passes;
//   a single key skips the sort). Draining reads each key in S_DRD, then loads
//   it in S_DLD. list.ready is low from the last key until the final key is
//   loaded into the output register; a new list may start while that key waits.
// Stall: a low sorted.ready holds the output register and the drain simply
//   waits; nothing is lost.
// Reset: the key count clears and the output register empties; the store
//   itself is not cleared, only entries written by the current list are read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sort_small_key_list
    import sks_pkg::*;
#(
    parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sks_in_if.sink     list,
    sks_out_if.source  sorted
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_DRD   = 3'd5;
    localparam logic [2:0] S_DLD   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    key_t          carry_reg, carry_next;
    logic          swapped_reg, swapped_next;
    logic          out_valid_reg, out_valid_next;
    key_t          out_key_reg, out_key_next;
    logic          out_eol_reg, out_eol_next;

    // memory and compare unit hookup
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    key_t          mem_wdata;
    logic [AW-1:0] mem_raddr;
    key_t          mem_rdata;
    key_t          cmp_lo, cmp_hi;
    logic          cmp_swap;

    logic          in_fire;
    logic          out_free;
    logic          has_room;
    logic [CW-1:0] n_last;
    logic [CW-1:0] count_inc;
    logic          at_last;

    sks_key_mem #(
        .DEPTH (MAX_KEYS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sks_minmax u_cmp (
        .a    (carry_reg),
        .b    (mem_rdata),
        .lo   (cmp_lo),
        .hi   (cmp_hi),
        .swap (cmp_swap)
    );

    // handshake and index helpers
    assign list.ready         = (state_reg == S_IDLE);
    assign in_fire            = list.valid && list.ready;
    assign out_free           = !out_valid_reg || sorted.ready;
    assign has_room           = (count_reg < CW'(MAX_KEYS));
    assign count_inc          = count_reg + CW'(1);
    assign n_last             = count_reg - CW'(1);
    assign at_last            = (CW'(idx_reg) == n_last);

    assign sorted.valid       = out_valid_reg;
    assign sorted.sorted_key  = out_key_reg;
    assign sorted.end_of_list = out_eol_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        carry_next     = carry_reg;
        swapped_next   = swapped_reg;
        out_valid_next = out_valid_reg && !sorted.ready;
        out_key_next   = out_key_reg;
        out_eol_next   = out_eol_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg - AW'(1);
        mem_wdata      = cmp_lo;
        mem_raddr      = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (has_room)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = list.key;
                        count_next = count_inc;
                    end
                    if (list.is_last)
                    begin
                        idx_next = '0;
                        if (count_next > CW'(1))
                        begin
                            state_next = S_START;
                        end
                        else
                        begin
                            state_next = S_DRD;
                        end
                    end
                end
            end

            // begin a pass: fetch entry 0
            S_START:
            begin
                mem_raddr    = '0;
                swapped_next = 1'b0;
                state_next   = S_FIRST;
            end

            // entry 0 becomes the carried key; fetch entry 1
            S_FIRST:
            begin
                carry_next = mem_rdata;
                mem_raddr  = AW'(1);
                idx_next   = AW'(1);
                state_next = S_PASS;
            end

            // compare carry with entry idx, settle the smaller at idx-1
            S_PASS:
            begin
                mem_we       = 1'b1;
                mem_waddr    = idx_reg - AW'(1);
                mem_wdata    = cmp_lo;
                carry_next   = cmp_hi;
                swapped_next = swapped_reg || cmp_swap;
                mem_raddr    = idx_reg + AW'(1);
                if (at_last)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            // the largest of the pass lands at the end
            S_TAIL:
            begin
                mem_we    = 1'b1;
                mem_waddr = n_last[AW-1:0];
                mem_wdata = carry_reg;
                if (swapped_reg)
                begin
                    state_next = S_START;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_DRD;
                end
            end

            // drain: fetch entry idx
            S_DRD:
            begin
                state_next = S_DLD;
            end

            // drain: load output register once it is free
            S_DLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = mem_rdata;
                    out_eol_next   = at_last;
                    if (at_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_DRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        carry_reg   <= carry_next;
        swapped_reg <= swapped_next;
        out_key_reg <= out_key_next;
        out_eol_reg <= out_eol_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_sort_small_key_list.sv =====
// ============================================================================
// tb_sort_small_key_list
// Self-checking bench for the small key list sorter.
// ----------------------------------------------------------------------------
// Keys go in one per request, in lists whose final key is marked. A
// behavioral sorter kept in the bench works out the ordered list each time
// a last key is taken. Every sorted request that comes out is checked
// against the oldest outstanding entry.
// The run has three stimulus phases:
//   - a short table of edge cases, with single-key lists typed in by hand;
//   - a list that overruns the store;
//   - random lists, including one long output stall that backs up the input.
// ============================================================================
`timescale 1ns / 1ps

module tb_sort_small_key_list;

    import sks_pkg::*;

    localparam int KEY_CAPACITY   = DEFAULT_MAX_KEYS;
    localparam int RANDOM_ITEMS   = 260;
    localparam int LONG_HOLD      = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TABLE_ROWS     = 20;
    localparam key_t KEY_ONE      = 17'd65536;
    localparam key_t KEY_TOP      = 17'h1FFFF;

    typedef struct packed {
        key_t sorted_key;
        logic end_of_list;
    } sorted_item_t;

    // Optional hand-typed answer for a single-key list
    typedef struct packed {
        logic has_known;
        key_t known_key;
    } known_note_t;

    typedef struct {
        key_t key;
        logic is_last;
        logic has_known;
        key_t known_key;
    } list_row_t;

    logic clk;
    logic rst_n;

    sks_in_if  list_ch ();
    sks_out_if sorted_ch ();

    sort_small_key_list #(
        .MAX_KEYS (KEY_CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .list   (list_ch.sink),
        .sorted (sorted_ch.source)
    );

    // Bench copy of the sorter state
    key_t         held_keys [KEY_CAPACITY];
    int           held_count;
    sorted_item_t pending_sorted [$];
    known_note_t  known_notes [$];

    int errors;
    int idle_cycles;
    int items_sent;
    int burst_left;
    bit hold_request;
    bit hold_done;

    // Edge cases; single-key lists carry their answer
    list_row_t list_table [TABLE_ROWS] = '{
        '{17'd0,      1'b1, 1'b1, 17'd0},
        '{KEY_ONE,    1'b1, 1'b1, KEY_ONE},
        '{KEY_TOP,    1'b1, 1'b1, KEY_TOP},
        '{17'd1,      1'b1, 1'b1, 17'd1},
        // reversed pair, one and zero
        '{KEY_ONE,    1'b0, 1'b0, 17'd0},
        '{17'd0,      1'b1, 1'b0, 17'd0},
        // equal keys around one half
        '{17'd32769,  1'b0, 1'b0, 17'd0},
        '{17'd32768,  1'b0, 1'b0, 17'd0},
        '{17'd32767,  1'b0, 1'b0, 17'd0},
        '{17'd32768,  1'b1, 1'b0, 17'd0},
        // already in order
        '{17'd1,      1'b0, 1'b0, 17'd0},
        '{17'd2,      1'b0, 1'b0, 17'd0},
        '{17'd3,      1'b1, 1'b0, 17'd0},
        // out-of-range key mixed into an unordered list
        '{KEY_TOP,    1'b0, 1'b0, 17'd0},
        '{17'd10000,  1'b0, 1'b0, 17'd0},
        '{KEY_ONE,    1'b0, 1'b0, 17'd0},
        '{17'd0,      1'b0, 1'b0, 17'd0},
        '{17'd5,      1'b1, 1'b0, 17'd0},
        // alternating bit patterns
        '{17'h0AAAA,  1'b0, 1'b0, 17'd0},
        '{17'h15555,  1'b1, 1'b0, 17'd0}
    };

    // Keep a key; on the last one, emit the kept keys in ascending order
    function automatic void absorb_key(input key_t key, input logic is_last,
                                       ref sorted_item_t out_q [$]);
        key_t ordered [KEY_CAPACITY];
        int   pos;
        if (held_count < KEY_CAPACITY)
        begin
            held_keys[held_count] = key;
            held_count++;
        end
        if (is_last)
        begin
            // insertion sort; equal keys stay adjacent
            for (int i = 0; i < held_count; i++)
            begin
                pos = i;
                while (pos > 0 && ordered[pos-1] > held_keys[i])
                begin
                    ordered[pos] = ordered[pos-1];
                    pos--;
                end
                ordered[pos] = held_keys[i];
            end
            for (int i = 0; i < held_count; i++)
                out_q.push_back('{sorted_key: ordered[i], end_of_list: (i == held_count - 1)});
            held_count = 0;
        end
    endfunction

    function automatic key_t pick_key();
        case ($urandom_range(0, 11))
            0:       return 17'd0;
            1:       return KEY_ONE;
            2:       return key_t'($urandom_range(65537, 131071));
            3:       return key_t'($urandom);
            4, 5:    return key_t'($urandom_range(0, 4) * 16384);
            default: return key_t'($urandom_range(0, 65536));
        endcase
    endfunction

    // Offer one key, idling first if the current burst is used up
    task automatic send_key(input key_t key, input logic is_last,
                            input logic has_known = 1'b0, input key_t known_key = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                list_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        known_notes.push_back('{has_known: has_known, known_key: known_key});
        list_ch.valid   <= 1'b1;
        list_ch.key     <= key;
        list_ch.is_last <= is_last;
        do
            @(posedge clk);
        while (!(list_ch.valid && list_ch.ready));
        items_sent++;
    endtask

    task automatic send_list(input int length);
        for (int i = 0; i < length; i++)
            send_key(pick_key(), i == length - 1);
    endtask

    // Stop offering and wait until every sorted request is back
    task automatic drain_sorted();
        list_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_sorted.size() != 0);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Reset and sender
    initial
    begin
        int length;
        errors       = 0;
        items_sent   = 0;
        burst_left   = 0;
        held_count   = 0;
        hold_request = 1'b0;
        rst_n           <= 1'b0;
        list_ch.valid   <= 1'b0;
        list_ch.key     <= '0;
        list_ch.is_last <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Edge-case table
        foreach (list_table[i])
            send_key(list_table[i].key, list_table[i].is_last,
                     list_table[i].has_known, list_table[i].known_key);
        drain_sorted();

        // Overrun the store: the last two keys are dropped, the last still sorts
        for (int i = 0; i < KEY_CAPACITY + 2; i++)
            send_key(key_t'(65536 - i * 1985), i == KEY_CAPACITY + 1);

        // Random lists
        while (items_sent < RANDOM_ITEMS + TABLE_ROWS + KEY_CAPACITY + 2)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: length = $urandom_range(1, 6);
                6, 7:             length = $urandom_range(7, 20);
                8:                length = $urandom_range(21, KEY_CAPACITY);
                default:          length = $urandom_range(KEY_CAPACITY + 1, KEY_CAPACITY + 8);
            endcase
            // Long output stall behind a full list, input keeps pushing
            if (!hold_request && items_sent > 120)
            begin
                hold_request = 1'b1;
                length       = KEY_CAPACITY;
            end
            send_list(length);
            if ($urandom_range(0, 11) == 0)
                drain_sorted();
        end

        drain_sorted();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: stall pattern of its own, plus one long hold on request
    initial
    begin
        int mode;
        int length;
        hold_done = 1'b0;
        sorted_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                sorted_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            mode   = $urandom_range(0, 3);
            length = $urandom_range(1, 40);
            repeat (length)
            begin
                case (mode)
                    0:       sorted_ch.ready <= 1'b1;
                    1:       sorted_ch.ready <= 1'($urandom_range(0, 1));
                    2:       sorted_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: sorted_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Predict on taken keys, check sorted requests, count idle cycles
    always @(posedge clk)
    begin : watch_channels
        sorted_item_t fresh [$];
        sorted_item_t want;
        known_note_t  note;
        logic         in_fire;
        logic         out_fire;
        if (rst_n)
        begin
            in_fire  = list_ch.valid && list_ch.ready;
            out_fire = sorted_ch.valid && sorted_ch.ready;

            if (in_fire)
            begin
                note = (known_notes.size() != 0) ? known_notes.pop_front() : '0;
                fresh.delete();
                absorb_key(list_ch.key, list_ch.is_last, fresh);
                if (note.has_known)
                    pending_sorted.push_back('{sorted_key: note.known_key, end_of_list: 1'b1});
                else
                    foreach (fresh[i]) pending_sorted.push_back(fresh[i]);
            end

            if (out_fire)
            begin
                if (pending_sorted.size() == 0)
                begin
                    $error("sorted request with nothing expected: sorted_key %0d end_of_list %0d",
                           sorted_ch.sorted_key, sorted_ch.end_of_list);
                    errors++;
                end
                else
                begin
                    want = pending_sorted.pop_front();
                    if (sorted_ch.sorted_key !== want.sorted_key)
                    begin
                        $error("sorted_key: expected %0d, actual %0d",
                               want.sorted_key, sorted_ch.sorted_key);
                        errors++;
                    end
                    if (sorted_ch.end_of_list !== want.end_of_list)
                    begin
                        $error("end_of_list: expected %0d, actual %0d",
                               want.end_of_list, sorted_ch.end_of_list);
                        errors++;
                    end
                end
            end

            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
        end
        else
            idle_cycles = 0;
    end

    // Watchdog on cycles with no traffic
    initial
    begin
        idle_cycles = 0;
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
